@@ design/ghcu_pkg.sv @@
`timescale 1ns / 1ps

package ghcu_pkg;

  localparam int KRYLOV_DEPTH = 32;
  localparam int ADDR_W = $clog2(KRYLOV_DEPTH);
  localparam int CNT_W = $clog2(KRYLOV_DEPTH + 1);
  localparam int IDX_W = $clog2(KRYLOV_DEPTH + 2);

  localparam logic [1:0] CLS_START = 2'd0;
  localparam logic [1:0] CLS_ELEM  = 2'd1;
  localparam logic [1:0] CLS_LAST  = 2'd2;

  localparam logic signed [31:0] ONE_Q24 = 32'sh0100_0000;

  typedef struct packed {
    logic              kind;
    logic signed [31:0] value;
    logic              last;
  } in_t;

  typedef struct packed {
    logic signed [31:0] diag_value;
    logic [5:0]         position;
    logic signed [31:0] rhs_entry;
    logic [30:0]        resid_mag;
    logic               is_last;
    logic               overflow;
  } out_t;

  typedef struct packed {
    logic [1:0]         cls;
    logic signed [31:0] value;
  } task_t;

  // Rounds a Q18.48 value to Q8.24 and saturates; bit 32 flags saturation.
  function automatic logic [32:0] round_sat(input logic signed [65:0] x);
    logic signed [65:0] t;
    t = (x + 66'sd8388608) >>> 24;
    if (t > 66'sd2147483647) begin
      return {1'b1, 32'h7fff_ffff};
    end else if (t < -66'sd2147483648) begin
      return {1'b1, 32'h8000_0000};
    end
    return {1'b0, t[31:0]};
  endfunction

endpackage

@@ design/givens_hessenberg_column_update_top.sv @@
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// input     in         in_valid / in_ready  in_data  (in_t: kind, value, last)
// output    out        out_valid/out_ready  out_data (out_t: diag_value ... overflow)
//
// A start item and the first element of a column are only stored; an element that
// overruns the column goes straight to the result; an element rotated by a stored
// rotation uses the shared multiplier. A closing element with a zero pivot goes straight
// to the rotation; otherwise the back sequencer runs the 32-step square root and two divisions.
// Reset is synchronous and clears the queue, the sequencer and the result valid flag.
// A two-entry input queue keeps accepting items, until it is full, while a result waits for out_ready.

module givens_hessenberg_column_update_top import ghcu_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  logic  q_valid;
  logic  q_ready;
  task_t q_item;

  ghcu_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_item   (q_item)
  );

  ghcu_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

@@ design/ghcu_front.sv @@
`timescale 1ns / 1ps

module ghcu_front import ghcu_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  in_t   in_data,
  output logic  q_valid,
  input  logic  q_ready,
  output task_t q_item
);

  task_t      slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  task_t      cls_item;
  logic       push;
  logic       pop;

  always_comb begin
    cls_item.value = in_data.value;
    if (!in_data.kind) begin
      cls_item.cls = CLS_START;
    end else if (in_data.last) begin
      cls_item.cls = CLS_LAST;
    end else begin
      cls_item.cls = CLS_ELEM;
    end
  end

  assign in_ready = (count != 2'd2);
  assign q_valid  = (count != 2'd0);
  assign q_item   = slots[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= cls_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("Queue count exceeds its depth.");

endmodule

@@ design/ghcu_back.sv @@
`timescale 1ns / 1ps

module ghcu_back import ghcu_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  q_valid,
  output logic  q_ready,
  input  task_t q_item,
  output logic  out_valid,
  input  logic  out_ready,
  output out_t  out_data
);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_M1   = 5'd1;
  localparam logic [4:0] S_M2   = 5'd2;
  localparam logic [4:0] S_M3   = 5'd3;
  localparam logic [4:0] S_M4   = 5'd4;
  localparam logic [4:0] S_M5   = 5'd5;
  localparam logic [4:0] S_H1   = 5'd6;
  localparam logic [4:0] S_H2   = 5'd7;
  localparam logic [4:0] S_H3   = 5'd8;
  localparam logic [4:0] S_SQ   = 5'd9;
  localparam logic [4:0] S_DVI  = 5'd10;
  localparam logic [4:0] S_DV   = 5'd11;
  localparam logic [4:0] S_D1   = 5'd12;
  localparam logic [4:0] S_D2   = 5'd13;
  localparam logic [4:0] S_D3   = 5'd14;
  localparam logic [4:0] S_D4   = 5'd15;
  localparam logic [4:0] S_D5   = 5'd16;
  localparam logic [4:0] S_OUT  = 5'd17;

  function automatic logic signed [32:0] mag33(input logic signed [31:0] x);
    logic signed [32:0] t;
    t = 33'(x);
    return t[32] ? -t : t;
  endfunction

  logic [4:0]         state;
  logic [IDX_W-1:0]   e;
  logic [CNT_W-1:0]   rc;
  logic signed [31:0] carry;
  logic signed [31:0] rhs;
  logic signed [31:0] cur_v;
  logic signed [31:0] pivot;
  logic signed [31:0] c_rd;
  logic signed [31:0] s_rd;
  logic signed [31:0] cs;
  logic signed [31:0] sn;
  logic signed [65:0] acc;
  logic signed [65:0] prod;
  logic               ovf;
  logic signed [31:0] diag;
  logic signed [31:0] rhs_out;
  logic [30:0]        norm;
  logic               is_last;
  logic [IDX_W-1:0]   row;
  logic [63:0]        sq_v;
  logic [63:0]        sq_res;
  logic [63:0]        sq_bit;
  logic [31:0]        rem;
  logic [24:0]        nlow;
  logic [24:0]        quo;
  logic [4:0]         cnt;
  logic               div_sel;

  logic signed [31:0] cos_mem [KRYLOV_DEPTH];
  logic signed [31:0] sin_mem [KRYLOV_DEPTH];

  logic signed [32:0] mul_x;
  logic signed [32:0] mul_y;
  logic signed [65:0] rnd_in;
  logic [32:0]        rs;
  logic signed [32:0] pa;
  logic signed [32:0] pb;
  logic [31:0]        hyp;
  logic [31:0]        dmag;
  logic [55:0]        num;
  logic [63:0]        sq_t;
  logic [32:0]        trial;
  logic               ge;
  logic [24:0]        q_next;
  logic signed [31:0] q_signed;
  logic               mem_we;
  logic [ADDR_W-1:0]  rd_addr;
  logic [ADDR_W-1:0]  wr_addr;
  logic signed [31:0] r_new;
  logic               take;

  assign q_ready = (state == S_IDLE);
  assign take    = q_valid && q_ready;
  assign pa      = mag33(pivot);
  assign pb      = mag33(cur_v);
  assign hyp     = sq_res[31:0];
  assign dmag    = div_sel ? pb[31:0] : pa[31:0];
  assign num     = {dmag, 24'b0} + 56'(hyp[31:1]);
  assign sq_t    = sq_res + sq_bit;
  assign trial   = {rem, nlow[24]};
  assign ge      = (trial >= {1'b0, hyp});
  assign q_next  = {quo[23:0], ge};
  assign rd_addr = ADDR_W'(e - IDX_W'(1));
  assign wr_addr = ADDR_W'(rc);
  assign mem_we  = (state == S_D5) && (rc < CNT_W'(KRYLOV_DEPTH));
  assign r_new   = rs[31:0];

  always_comb begin
    if ((div_sel ? cur_v[31] : pivot[31])) begin
      q_signed = -$signed({7'b0, q_next});
    end else begin
      q_signed = $signed({7'b0, q_next});
    end
  end

  always_comb begin
    mul_x = '0;
    mul_y = '0;
    case (state)
      S_M1: begin mul_x = 33'(c_rd); mul_y = 33'(carry); end
      S_M2: begin mul_x = 33'(s_rd); mul_y = 33'(cur_v); end
      S_M3: begin mul_x = 33'(c_rd); mul_y = 33'(cur_v); end
      S_M4: begin mul_x = 33'(s_rd); mul_y = 33'(carry); end
      S_H1: begin mul_x = pa; mul_y = pa; end
      S_H2: begin mul_x = pb; mul_y = pb; end
      S_D1: begin mul_x = 33'(cs); mul_y = 33'(pivot); end
      S_D2: begin mul_x = 33'(sn); mul_y = 33'(cur_v); end
      S_D3: begin mul_x = 33'(cs); mul_y = 33'(rhs); end
      S_D4: begin mul_x = 33'(sn); mul_y = 33'(rhs); end
      default: begin mul_x = '0; mul_y = '0; end
    endcase
  end

  always_comb begin
    case (state)
      S_M3, S_D3: rnd_in = acc + prod;
      S_M5:       rnd_in = acc - prod;
      S_D4:       rnd_in = prod;
      S_D5:       rnd_in = -prod;
      default:    rnd_in = prod;
    endcase
    rs = round_sat(rnd_in);
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      cos_mem[wr_addr] <= cs;
      sin_mem[wr_addr] <= sn;
    end
    if (state == S_IDLE) begin
      c_rd <= cos_mem[rd_addr];
      s_rd <= sin_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    prod <= 66'(mul_x) * 66'(mul_y);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      e         <= '0;
      rc        <= '0;
      carry     <= '0;
      rhs       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (take) begin
            cur_v   <= q_item.value;
            rhs_out <= '0;
            norm    <= '0;
            is_last <= (q_item.cls == CLS_LAST);
            case (q_item.cls)
              CLS_START: begin
                rhs   <= q_item.value;
                rc    <= '0;
                e     <= '0;
                carry <= '0;
              end
              CLS_ELEM: begin
                if (e == '0) begin
                  carry <= q_item.value;
                  e     <= IDX_W'(1);
                end else begin
                  row <= e - IDX_W'(1);
                  if (e < IDX_W'(KRYLOV_DEPTH + 1)) begin
                    e <= e + IDX_W'(1);
                  end
                  if (e <= IDX_W'(rc)) begin
                    ovf   <= 1'b0;
                    state <= S_M1;
                  end else begin
                    ovf   <= 1'b1;
                    diag  <= carry;
                    carry <= q_item.value;
                    state <= S_OUT;
                  end
                end
              end
              default: begin
                ovf     <= 1'b0;
                pivot   <= (e == '0) ? 32'sd0 : carry;
                row     <= (e == '0) ? '0 : e - IDX_W'(1);
                div_sel <= 1'b0;
                e       <= '0;
                carry   <= '0;
                if (e == '0 || carry == 32'sd0) begin
                  cs    <= 32'sd0;
                  sn    <= ONE_Q24;
                  state <= S_D1;
                end else begin
                  state <= S_H1;
                end
              end
            endcase
          end
        end
        S_M1: state <= S_M2;
        S_M2: begin
          acc   <= prod;
          state <= S_M3;
        end
        S_M3: begin
          diag  <= r_new;
          ovf   <= ovf | rs[32];
          state <= S_M4;
        end
        S_M4: begin
          acc   <= prod;
          state <= S_M5;
        end
        S_M5: begin
          carry <= r_new;
          ovf   <= ovf | rs[32];
          state <= S_OUT;
        end
        S_H1: state <= S_H2;
        S_H2: begin
          acc   <= prod;
          state <= S_H3;
        end
        S_H3: begin
          sq_v   <= 64'(acc + prod);
          sq_res <= '0;
          sq_bit <= 64'h4000_0000_0000_0000;
          state  <= S_SQ;
        end
        S_SQ: begin
          if (sq_v >= sq_t) begin
            sq_v   <= sq_v - sq_t;
            sq_res <= (sq_res >> 1) + sq_bit;
          end else begin
            sq_res <= sq_res >> 1;
          end
          sq_bit <= sq_bit >> 2;
          if (sq_bit == 64'd1) begin
            state <= S_DVI;
          end
        end
        S_DVI: begin
          rem   <= 32'(num[55:25]);
          nlow  <= num[24:0];
          quo   <= '0;
          cnt   <= '0;
          state <= S_DV;
        end
        S_DV: begin
          rem  <= ge ? 32'(trial - {1'b0, hyp}) : trial[31:0];
          nlow <= {nlow[23:0], 1'b0};
          quo  <= q_next;
          cnt  <= cnt + 5'd1;
          if (cnt == 5'd24) begin
            if (!div_sel) begin
              cs      <= q_signed;
              div_sel <= 1'b1;
              state   <= S_DVI;
            end else begin
              sn    <= q_signed;
              state <= S_D1;
            end
          end
        end
        S_D1: state <= S_D2;
        S_D2: begin
          acc   <= prod;
          state <= S_D3;
        end
        S_D3: begin
          diag  <= r_new;
          ovf   <= ovf | rs[32];
          state <= S_D4;
        end
        S_D4: begin
          rhs_out <= r_new;
          ovf     <= ovf | rs[32];
          state   <= S_D5;
        end
        S_D5: begin
          rhs <= r_new;
          if (r_new == 32'sh8000_0000) begin
            norm <= 31'h7fff_ffff;
          end else begin
            norm <= r_new[31] ? 31'(-r_new) : r_new[30:0];
          end
          ovf <= ovf | rs[32] | (r_new == 32'sh8000_0000)
                 | (rc >= CNT_W'(KRYLOV_DEPTH));
          if (rc < CNT_W'(KRYLOV_DEPTH)) begin
            rc <= rc + CNT_W'(1);
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_data.diag_value <= diag;
            out_data.position   <= 6'(row);
            out_data.rhs_entry  <= rhs_out;
            out_data.resid_mag  <= norm;
            out_data.is_last    <= is_last;
            out_data.overflow   <= ovf;
            out_valid           <= 1'b1;
            state               <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) rc <= CNT_W'(KRYLOV_DEPTH))
    else $error("Rotation count exceeds the store depth.");

  assert property (@(posedge clk) disable iff (rst)
    (take && q_item.cls == CLS_LAST) |=> (e == '0))
    else $error("Element index not cleared after the closing element.");

  assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && (!out_valid || out_ready)) |=> (out_valid && state == S_IDLE))
    else $error("Result not presented when the output register was free.");

endmodule
